// ===== hdl/ara_pkg.sv =====
package ara_pkg;

    localparam int FIELD_W      = 48;
    localparam int ALIGN_W      = 6;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;

    localparam int MAX_GAPS_DEF  = 64;
    localparam int ADDR_BITS_DEF = 48;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT = 2'd1;

    // control from the sequencer to every cell of the gap ring
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== hdl/ara_in_if.sv =====
interface ara_in_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [ara_pkg::FIELD_W-1:0]    req_size;
    logic [ara_pkg::ALIGN_W-1:0]    align_log2;
    logic [ara_pkg::FIELD_W-1:0]    free_address;

    modport source (output valid, opcode, req_size, align_log2, free_address, input ready);
    modport sink   (input valid, opcode, req_size, align_log2, free_address, output ready);
endinterface

// ===== hdl/ara_out_if.sv =====
interface ara_out_if;
    logic                           valid;
    logic                           ready;
    logic [ara_pkg::FIELD_W-1:0]    alloc_address;
    logic [ara_pkg::STATUS_W-1:0]   status;
    logic [ara_pkg::FIELD_W-1:0]    free_bytes;

    modport source (output valid, alloc_address, status, free_bytes, input ready);
    modport sink   (input valid, alloc_address, status, free_bytes, output ready);
endinterface

// ===== hdl/ara_cfg_if.sv =====
interface ara_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ara_pkg::CFG_IDX_W-1:0]  index;
    logic [ara_pkg::FIELD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/aligned_range_allocator_core.sv =====
// First-fit address range allocator. Free gaps live in a ring of cells,
// sorted by start address; cell 0 holds the lowest gap.
// Channels: i_in takes allocate/free beats, o_out returns one result beat
// per input beat in order, i_cfg writes pool_base (0) and pool_limit (1).
// A config write rebuilds the table as one gap [base, limit), or as an
// empty table if limit <= base; write only while no item is in flight.
// Other indexes are ignored. An item that changes the table makes one
// full rotation of the ring to search and one to write back the edited
// sequence. An item that fails after the search skips the write-back; a
// zero-size item or a free past the address space skips the search too.
// One item is worked on at a time; i_in.ready is high only when the
// sequencer is idle. The result sits in an output register; a stalled
// receiver holds it while the next item is accepted and searched, and
// the sequencer waits at completion until that register frees up.
// Reset (synchronous, active low) clears the pool to base = limit = 0,
// leaving an empty table; gap cells themselves are not cleared.
module aligned_range_allocator_core #(
    parameter int MAX_GAPS  = ara_pkg::MAX_GAPS_DEF,
    parameter int ADDR_BITS = ara_pkg::ADDR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ara_in_if.sink    i_in,
    ara_out_if.source o_out,
    ara_cfg_if.sink   i_cfg
);

    localparam int A = ADDR_BITS;

    ara_pkg::t_cell_ctl w_ctl;
    ara_pkg::t_cell_ctl w_cell_ctl [MAX_GAPS];
    logic [A-1:0] w_ld_start, w_h_start;
    logic [A:0]   w_ld_end, w_h_end;
    logic [A-1:0] w_start [MAX_GAPS];
    logic [A:0]   w_end   [MAX_GAPS];

    ara_ctrl #(
        .MAX_GAPS  (MAX_GAPS),
        .ADDR_BITS (ADDR_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg      (i_cfg),
        .i_c0_start (w_start[0]),
        .i_c0_end   (w_end[0]),
        .i_c1_start (w_start[1]),
        .i_c1_end   (w_end[1]),
        .o_ctl      (w_ctl),
        .o_ld_start (w_ld_start),
        .o_ld_end   (w_ld_end),
        .o_h_start  (w_h_start),
        .o_h_end    (w_h_end)
    );

    genvar g;
    generate
        for (g = 0; g < MAX_GAPS; g++) begin : g_cell
            // only cell 0 takes the rebuild load
            assign w_cell_ctl[g] = {w_ctl.shift, (g == 0) ? w_ctl.load : 1'b0};

            if (g == MAX_GAPS - 1) begin : g_tail
                ara_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (w_cell_ctl[g]),
                    .i_ld_start (w_ld_start),
                    .i_ld_end   (w_ld_end),
                    .i_nb_start (w_h_start),
                    .i_nb_end   (w_h_end),
                    .o_start    (w_start[g]),
                    .o_end      (w_end[g])
                );
            end else begin : g_body
                ara_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (w_cell_ctl[g]),
                    .i_ld_start (w_ld_start),
                    .i_ld_end   (w_ld_end),
                    .i_nb_start (w_start[g+1]),
                    .i_nb_end   (w_end[g+1]),
                    .o_start    (w_start[g]),
                    .o_end      (w_end[g])
                );
            end
        end
    endgenerate

endmodule

// ===== hdl/ara_cell.sv =====
module ara_cell #(
    parameter int ADDR_BITS = ara_pkg::ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  ara_pkg::t_cell_ctl    i_ctl,
    input  logic [ADDR_BITS-1:0]  i_ld_start,
    input  logic [ADDR_BITS:0]    i_ld_end,
    input  logic [ADDR_BITS-1:0]  i_nb_start,
    input  logic [ADDR_BITS:0]    i_nb_end,
    output logic [ADDR_BITS-1:0]  o_start,
    output logic [ADDR_BITS:0]    o_end
);

    logic [ADDR_BITS-1:0] r_start, n_start;
    logic [ADDR_BITS:0]   r_end, n_end;

    always_comb begin
        n_start = r_start;
        n_end   = r_end;
        if (i_ctl.load) begin
            n_start = i_ld_start;
            n_end   = i_ld_end;
        end else if (i_ctl.shift) begin
            n_start = i_nb_start;
            n_end   = i_nb_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
    end

    assign o_start = r_start;
    assign o_end   = r_end;

endmodule

// ===== hdl/ara_ctrl.sv =====
module ara_ctrl #(
    parameter int MAX_GAPS  = ara_pkg::MAX_GAPS_DEF,
    parameter int ADDR_BITS = ara_pkg::ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ara_in_if.sink                i_in,
    ara_out_if.source             o_out,
    ara_cfg_if.sink               i_cfg,
    input  logic [ADDR_BITS-1:0]  i_c0_start,
    input  logic [ADDR_BITS:0]    i_c0_end,
    input  logic [ADDR_BITS-1:0]  i_c1_start,
    input  logic [ADDR_BITS:0]    i_c1_end,
    output ara_pkg::t_cell_ctl    o_ctl,
    output logic [ADDR_BITS-1:0]  o_ld_start,
    output logic [ADDR_BITS:0]    o_ld_end,
    output logic [ADDR_BITS-1:0]  o_h_start,
    output logic [ADDR_BITS:0]    o_h_end
);

    localparam int A  = ADDR_BITS;
    localparam int FW = ara_pkg::FIELD_W;
    localparam int KW = (A < FW) ? A : FW;
    localparam int W2 = A + 2;
    localparam int CW = $clog2(MAX_GAPS + 1);
    localparam logic [CW-1:0] LAST = CW'(MAX_GAPS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_EDIT   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]                     r_state, n_state;
    logic [A-1:0]                   r_base, n_base, r_limit, n_limit;
    logic [CW-1:0]                  r_count, n_count;
    logic [A-1:0]                   r_ftot, n_ftot;
    logic                           r_op, n_op;
    logic [A-1:0]                   r_size, n_size, r_addr, n_addr;
    logic [ara_pkg::ALIGN_W-1:0]    r_lg, n_lg;
    logic [A:0]                     r_endf, n_endf;
    logic [CW-1:0]                  r_j, n_j;
    // one entry popped from the ring, waiting for its compare
    logic                           r_pv, n_pv;
    logic [A-1:0]                   r_ps, n_ps;
    logic [A:0]                     r_pe, n_pe;
    logic [CW-1:0]                  r_pj, n_pj;
    logic [W2-1:0]                  r_psum, n_psum;
    // prev doubles as the first-fit hit on allocate
    logic                           r_prv, n_prv, r_nxv, n_nxv;
    logic [CW-1:0]                  r_prj, n_prj, r_nxj, n_nxj;
    logic [A-1:0]                   r_prs, n_prs, r_nxs, n_nxs;
    logic [A:0]                     r_pre, n_pre, r_nxe, n_nxe;
    logic [A-1:0]                   r_fal, n_fal;
    logic [A:0]                     r_fenda, n_fenda;
    // edit of the ring for the rewrite pass
    logic                           r_rep_en, n_rep_en, r_ins_en, n_ins_en;
    logic                           r_rem_en, n_rem_en, r_ins_act, n_ins_act;
    logic [CW-1:0]                  r_rep_j, n_rep_j, r_ins_j, n_ins_j, r_rem_j, n_rem_j;
    logic [A-1:0]                   r_rep_s, n_rep_s, r_ins_s, n_ins_s;
    logic [A:0]                     r_rep_e, n_rep_e, r_ins_e, n_ins_e;
    logic [A-1:0]                   r_p_s, n_p_s, r_h_s, n_h_s;
    logic [A:0]                     r_p_e, n_p_e, r_h_e, n_h_e;
    logic [A-1:0]                   r_res_addr, n_res_addr;
    logic [ara_pkg::STATUS_W-1:0]   r_res_st, n_res_st;
    logic                           r_out_valid, n_out_valid;
    logic [FW-1:0]                  r_out_addr, n_out_addr, r_out_free, n_out_free;
    logic [ara_pkg::STATUS_W-1:0]   r_out_st, n_out_st;

    logic [W2-1:0]  mask, al, enda;
    logic           fit, below, left, right, full, overlap, mprev, mnext;
    logic [A:0]     endf, ft_add;
    logic [A-1:0]   ft_sub, ft_sat, in_size, in_addr, cfg_val, nb, nl;
    logic [CW-1:0]  pos;
    logic [A-1:0]   ej_s;
    logic [A:0]     ej_e;
    logic           in_fire, cfg_fire, out_fire;

    always_comb begin
        for (int i = 0; i < W2; i++) begin
            mask[i] = (i < int'(r_lg)) && (i < A + 1);
        end
    end

    assign in_size = A'(i_in.req_size[KW-1:0]);
    assign in_addr = A'(i_in.free_address[KW-1:0]);
    assign cfg_val = A'(i_cfg.data[KW-1:0]);

    assign al      = r_psum & ~mask;
    assign enda    = al + W2'(r_size);
    assign fit     = enda <= W2'(r_pe);
    assign below   = {1'b0, r_ps} < r_endf;
    assign endf    = (A+1)'(r_addr) + (A+1)'(r_size);

    assign left    = r_fal > r_prs;
    assign right   = r_fenda < r_pre;
    assign full    = r_count == LAST;
    assign overlap = r_prv && (r_pre > {1'b0, r_addr});
    assign mprev   = r_prv && (r_pre == {1'b0, r_addr});
    assign mnext   = r_nxv && ({1'b0, r_nxs} == r_endf);
    assign pos     = r_nxv ? r_nxj : r_count;

    assign ft_sub  = (r_ftot >= r_size) ? (r_ftot - r_size) : '0;
    assign ft_add  = (A+1)'(r_ftot) + (A+1)'(r_size);
    assign ft_sat  = ft_add[A] ? '1 : ft_add[A-1:0];

    assign ej_s    = (r_rep_en && (r_j == r_rep_j)) ? r_rep_s : i_c0_start;
    assign ej_e    = (r_rep_en && (r_j == r_rep_j)) ? r_rep_e : i_c0_end;

    assign nb      = (i_cfg.index == ara_pkg::CFG_POOL_BASE) ? cfg_val : r_base;
    assign nl      = (i_cfg.index == ara_pkg::CFG_POOL_LIMIT) ? cfg_val : r_limit;

    assign in_fire  = i_in.valid && i_in.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign out_fire = o_out.valid && o_out.ready;

    always_comb begin
        n_state = r_state;   n_base = r_base;     n_limit = r_limit;
        n_count = r_count;   n_ftot = r_ftot;     n_op = r_op;
        n_size = r_size;     n_addr = r_addr;     n_lg = r_lg;
        n_endf = r_endf;     n_j = r_j;
        n_pv = 1'b0;         n_ps = r_ps;         n_pe = r_pe;
        n_pj = r_pj;         n_psum = r_psum;
        n_prv = r_prv;       n_prj = r_prj;       n_prs = r_prs;     n_pre = r_pre;
        n_nxv = r_nxv;       n_nxj = r_nxj;       n_nxs = r_nxs;     n_nxe = r_nxe;
        n_fal = r_fal;       n_fenda = r_fenda;
        n_rep_en = r_rep_en; n_rep_j = r_rep_j;   n_rep_s = r_rep_s; n_rep_e = r_rep_e;
        n_ins_en = r_ins_en; n_ins_j = r_ins_j;   n_ins_s = r_ins_s; n_ins_e = r_ins_e;
        n_rem_en = r_rem_en; n_rem_j = r_rem_j;   n_ins_act = r_ins_act;
        n_p_s = r_p_s;       n_p_e = r_p_e;       n_h_s = r_h_s;     n_h_e = r_h_e;
        n_res_addr = r_res_addr;                  n_res_st = r_res_st;
        n_out_valid = r_out_valid;
        n_out_addr = r_out_addr; n_out_st = r_out_st; n_out_free = r_out_free;
        o_ctl.shift = 1'b0;
        o_ctl.load  = 1'b0;
        o_ld_start  = nb;
        o_ld_end    = {1'b0, nl};

        // compare stage for the entry popped last cycle
        if (r_pv) begin
            if (r_op == ara_pkg::OP_ALLOC) begin
                if (!r_prv && fit) begin
                    n_prv = 1'b1; n_prj = r_pj; n_prs = r_ps; n_pre = r_pe;
                    n_fal = al[A-1:0];
                    n_fenda = enda[A:0];
                end
            end else if (below) begin
                n_prv = 1'b1; n_prj = r_pj; n_prs = r_ps; n_pre = r_pe;
            end else if (!r_nxv) begin
                n_nxv = 1'b1; n_nxj = r_pj; n_nxs = r_ps; n_nxe = r_pe;
            end
        end

        if (out_fire) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op    = i_in.opcode;
                    n_size  = in_size;
                    n_lg    = i_in.align_log2;
                    n_addr  = in_addr;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_endf = endf;
                n_prv = 1'b0; n_nxv = 1'b0; n_j = '0;
                n_rep_en = 1'b0; n_ins_en = 1'b0; n_rem_en = 1'b0; n_ins_act = 1'b0;
                n_res_addr = '0;
                n_res_st = ara_pkg::ST_OK;
                if (r_size == '0) begin
                    n_res_st = (r_op == ara_pkg::OP_ALLOC) ? ara_pkg::ST_NOFIT
                                                           : ara_pkg::ST_OK;
                    n_state = S_DONE;
                end else if (r_op == ara_pkg::OP_FREE && endf[A] && (|endf[A-1:0])) begin
                    n_res_st = ara_pkg::ST_OVERLAP;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // rotate the ring once, looking at each gap as it passes cell 0
                o_ctl.shift = 1'b1;
                n_h_s  = i_c0_start;
                n_h_e  = i_c0_end;
                n_pv   = r_j < r_count;
                n_ps   = i_c0_start;
                n_pe   = i_c0_end;
                n_pj   = r_j;
                n_psum = W2'(i_c0_start) + mask;
                n_j    = r_j + CW'(1);
                if (r_j == LAST) begin
                    n_j = '0;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_op == ara_pkg::OP_ALLOC) begin
                    if (!r_prv) begin
                        n_res_st = ara_pkg::ST_NOFIT;
                    end else if (left && right && full) begin
                        n_res_st = ara_pkg::ST_FULL;
                    end else begin
                        n_res_st   = ara_pkg::ST_OK;
                        n_res_addr = r_fal;
                        n_ftot     = ft_sub;
                        n_state    = S_EDIT;
                        n_rep_j    = r_prj;
                        if (left && right) begin
                            n_rep_en = 1'b1; n_rep_s = r_prs; n_rep_e = {1'b0, r_fal};
                            n_ins_en = 1'b1; n_ins_j = r_prj + CW'(1);
                            n_ins_s  = r_fenda[A-1:0]; n_ins_e = r_pre;
                            n_count  = r_count + CW'(1);
                        end else if (left) begin
                            n_rep_en = 1'b1; n_rep_s = r_prs; n_rep_e = {1'b0, r_fal};
                        end else if (right) begin
                            n_rep_en = 1'b1; n_rep_s = r_fenda[A-1:0]; n_rep_e = r_pre;
                        end else begin
                            n_rem_en = 1'b1; n_rem_j = r_prj;
                            n_count  = r_count - CW'(1);
                        end
                    end
                end else begin
                    if (overlap) begin
                        n_res_st = ara_pkg::ST_OVERLAP;
                    end else if (!mprev && !mnext && full) begin
                        n_res_st = ara_pkg::ST_FULL;
                    end else begin
                        n_res_st = ara_pkg::ST_OK;
                        n_ftot   = ft_sat;
                        n_state  = S_EDIT;
                        if (mprev && mnext) begin
                            n_rep_en = 1'b1; n_rep_j = r_prj; n_rep_s = r_prs; n_rep_e = r_nxe;
                            n_rem_en = 1'b1; n_rem_j = r_nxj;
                            n_count  = r_count - CW'(1);
                        end else if (mprev) begin
                            n_rep_en = 1'b1; n_rep_j = r_prj; n_rep_s = r_prs; n_rep_e = r_endf;
                        end else if (mnext) begin
                            n_rep_en = 1'b1; n_rep_j = r_nxj; n_rep_s = r_addr; n_rep_e = r_nxe;
                        end else begin
                            n_ins_en = 1'b1; n_ins_j = pos; n_ins_s = r_addr; n_ins_e = r_endf;
                            n_count  = r_count + CW'(1);
                        end
                    end
                end
            end
            S_EDIT: begin
                // second rotation: write the edited sequence back through the hold stage
                o_ctl.shift = 1'b1;
                if (r_rem_en && (r_j >= r_rem_j)) begin
                    n_h_s = i_c1_start;
                    n_h_e = i_c1_end;
                end else if (r_ins_en && (r_j == r_ins_j)) begin
                    n_h_s = r_ins_s; n_h_e = r_ins_e;
                    n_p_s = ej_s;    n_p_e = ej_e;
                    n_ins_act = 1'b1;
                end else if (r_ins_act) begin
                    n_h_s = r_p_s; n_h_e = r_p_e;
                    n_p_s = ej_s;  n_p_e = ej_e;
                end else begin
                    n_h_s = ej_s;
                    n_h_e = ej_e;
                end
                n_j = r_j + CW'(1);
                if (r_j == LAST) begin
                    n_j = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = FW'(r_res_addr[KW-1:0]);
                    n_out_st    = r_res_st;
                    n_out_free  = FW'(r_ftot[KW-1:0]);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write rebuilds the table as a single gap in cell 0
        if (cfg_fire && (i_cfg.index == ara_pkg::CFG_POOL_BASE ||
                         i_cfg.index == ara_pkg::CFG_POOL_LIMIT)) begin
            n_base = nb;
            n_limit = nl;
            o_ctl.load = 1'b1;
            if (nl > nb) begin
                n_count = CW'(1);
                n_ftot  = nl - nb;
            end else begin
                n_count = '0;
                n_ftot  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_limit     <= '0;
            r_count     <= '0;
            r_ftot      <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_limit     <= n_limit;
            r_count     <= n_count;
            r_ftot      <= n_ftot;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;         r_size <= n_size;     r_addr <= n_addr;   r_lg <= n_lg;
        r_endf <= n_endf;     r_j <= n_j;
        r_ps <= n_ps;         r_pe <= n_pe;         r_pj <= n_pj;       r_psum <= n_psum;
        r_prv <= n_prv;       r_prj <= n_prj;       r_prs <= n_prs;     r_pre <= n_pre;
        r_nxv <= n_nxv;       r_nxj <= n_nxj;       r_nxs <= n_nxs;     r_nxe <= n_nxe;
        r_fal <= n_fal;       r_fenda <= n_fenda;
        r_rep_en <= n_rep_en; r_rep_j <= n_rep_j;   r_rep_s <= n_rep_s; r_rep_e <= n_rep_e;
        r_ins_en <= n_ins_en; r_ins_j <= n_ins_j;   r_ins_s <= n_ins_s; r_ins_e <= n_ins_e;
        r_rem_en <= n_rem_en; r_rem_j <= n_rem_j;   r_ins_act <= n_ins_act;
        r_p_s <= n_p_s;       r_p_e <= n_p_e;       r_h_s <= n_h_s;     r_h_e <= n_h_e;
        r_res_addr <= n_res_addr;                   r_res_st <= n_res_st;
        r_out_addr <= n_out_addr; r_out_st <= n_out_st; r_out_free <= n_out_free;
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.alloc_address = r_out_addr;
    assign o_out.status        = r_out_st;
    assign o_out.free_bytes    = r_out_free;
    assign o_h_start           = r_h_s;
    assign o_h_end             = r_h_e;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST)
        else $error("gap count above table size");

    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == S_PREP)
        else $error("accepted beat did not start an item");

    a_fail_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && n_state == S_DONE && !cfg_fire) |=> $stable(r_count))
        else $error("failed item changed the table");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside completion");

    a_edit_with_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDIT) |-> (r_rep_en || r_ins_en || r_rem_en))
        else $error("rewrite pass without an edit");

endmodule

// ===== tb/ara_tb_pkg.sv =====
package ara_tb_pkg;
    // size of the gap table, shared by the stimulus and the checker
    localparam int TB_GAPS = ara_pkg::MAX_GAPS_DEF;
endpackage

// ===== tb/ara_result_checker.sv =====
module ara_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ara_in_if.sink        mon_in,
    ara_out_if.sink       mon_out,
    ara_cfg_if.sink       mon_cfg,
    output int            o_errors,
    output int            o_pending,
    output int            o_results
);

    typedef logic [ara_pkg::FIELD_W-1:0] t_addr;
    typedef struct packed {
        t_addr                          addr;
        logic [ara_pkg::STATUS_W-1:0]   status;
        t_addr                          free_bytes;
    } t_result;

    localparam logic [63:0] AMASK = (64'd1 << ara_pkg::ADDR_BITS_DEF) - 64'd1;
    localparam int NG = ara_tb_pkg::TB_GAPS;

    logic [63:0] pool_lo, pool_hi, free_sum;
    logic [63:0] g_start [NG];
    logic [63:0] g_len   [NG];
    int          g_cnt;
    t_result     exp_q [$];
    int          err_cnt = 0;
    int          res_cnt = 0;
    int          pend_cnt = 0;

    assign o_errors  = err_cnt;
    assign o_results = res_cnt;
    assign o_pending = pend_cnt;

    function automatic void rebuild_gaps();
        g_cnt = 0;
        free_sum = 0;
        if (pool_hi > pool_lo) begin
            g_start[0] = pool_lo;
            g_len[0]   = pool_hi - pool_lo;
            g_cnt      = 1;
            free_sum   = g_len[0];
        end
    endfunction

    function automatic void drop_gap(int i);
        for (int k = i; k + 1 < g_cnt; k++) begin
            g_start[k] = g_start[k+1];
            g_len[k]   = g_len[k+1];
        end
        g_cnt--;
    endfunction

    function automatic void add_gap(int i, logic [63:0] s, logic [63:0] l);
        for (int k = g_cnt; k > i; k--) begin
            g_start[k] = g_start[k-1];
            g_len[k]   = g_len[k-1];
        end
        g_start[i] = s;
        g_len[i]   = l;
        g_cnt++;
    endfunction

    function automatic logic [1:0] carve(logic [63:0] size, int lg,
                                         output logic [63:0] addr);
        logic [63:0] al_mask, s, gend, al, e;
        logic lft, rgt;
        al_mask = (64'd1 << lg) - 64'd1;
        addr = 0;
        if (size == 0) return ara_pkg::ST_NOFIT;
        for (int i = 0; i < g_cnt; i++) begin
            s    = g_start[i];
            gend = s + g_len[i];
            al   = (s + al_mask) & ~al_mask;
            if (al > gend || gend - al < size) continue;
            e   = al + size;
            lft = al > s;
            rgt = e < gend;
            if (lft && rgt && g_cnt >= NG) return ara_pkg::ST_FULL;
            if (lft && rgt) begin
                g_len[i] = al - s;
                add_gap(i + 1, e, gend - e);
            end else if (lft) begin
                g_len[i] = al - s;
            end else if (rgt) begin
                g_start[i] = e;
                g_len[i]   = gend - e;
            end else begin
                drop_gap(i);
            end
            free_sum = (free_sum >= size) ? free_sum - size : 0;
            addr = al;
            return ara_pkg::ST_OK;
        end
        return ara_pkg::ST_NOFIT;
    endfunction

    function automatic logic [1:0] release_range(logic [63:0] a, logic [63:0] size);
        logic [63:0] e, s, gend;
        int pos;
        logic mp, mn;
        e = a + size;
        if (size == 0) return ara_pkg::ST_OK;
        if (e > AMASK + 64'd1) return ara_pkg::ST_OVERLAP;
        pos = g_cnt;
        for (int i = 0; i < g_cnt; i++) begin
            s    = g_start[i];
            gend = s + g_len[i];
            if (e > s && a < gend) return ara_pkg::ST_OVERLAP;
            if (s >= e && pos == g_cnt) pos = i;
        end
        mp = pos > 0 && g_start[pos-1] + g_len[pos-1] == a;
        mn = pos < g_cnt && g_start[pos] == e;
        if (!mp && !mn && g_cnt >= NG) return ara_pkg::ST_FULL;
        if (mp && mn) begin
            g_len[pos-1] += size + g_len[pos];
            drop_gap(pos);
        end else if (mp) begin
            g_len[pos-1] += size;
        end else if (mn) begin
            g_start[pos] = a;
            g_len[pos]  += size;
        end else begin
            add_gap(pos, a, size);
        end
        free_sum += size;
        if (free_sum > AMASK) free_sum = AMASK;
        return ara_pkg::ST_OK;
    endfunction

    always @(posedge i_clk) begin
        t_result r, got;
        logic [63:0] a;
        if (!i_rst_n) begin
            pool_lo = 0;
            pool_hi = 0;
            rebuild_gaps();
            exp_q.delete();
        end else begin
            if (mon_cfg.valid && mon_cfg.ready) begin
                if (mon_cfg.index == ara_pkg::CFG_POOL_BASE) begin
                    pool_lo = {16'd0, mon_cfg.data};
                    rebuild_gaps();
                end else if (mon_cfg.index == ara_pkg::CFG_POOL_LIMIT) begin
                    pool_hi = {16'd0, mon_cfg.data};
                    rebuild_gaps();
                end
            end
            if (mon_out.valid && mon_out.ready) begin
                got = '{mon_out.alloc_address, mon_out.status, mon_out.free_bytes};
                res_cnt <= res_cnt + 1;
                if (exp_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $time, got);
                    err_cnt <= err_cnt + 1;
                end else begin
                    r = exp_q.pop_front();
                    if (got !== r) begin
                        $display("%0t: mismatch addr exp %h got %h, status exp %0d got %0d,",
                                 $time, r.addr, got.addr, r.status, got.status);
                        $display("    free exp %h got %h", r.free_bytes, got.free_bytes);
                        err_cnt <= err_cnt + 1;
                    end
                end
            end
            if (mon_in.valid && mon_in.ready) begin
                if (mon_in.opcode == ara_pkg::OP_ALLOC) begin
                    r.status = carve({16'd0, mon_in.req_size}, int'(mon_in.align_log2), a);
                end else begin
                    a = 0;
                    r.status = release_range({16'd0, mon_in.free_address},
                                             {16'd0, mon_in.req_size});
                end
                r.addr = a[ara_pkg::FIELD_W-1:0];
                r.free_bytes = free_sum[ara_pkg::FIELD_W-1:0];
                exp_q.push_back(r);
            end
        end
        pend_cnt = exp_q.size();
    end
endmodule

// ===== tb/tb_aligned_range_allocator_core.sv =====
module tb_aligned_range_allocator_core;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending, results;
    logic stall_go = 1'b0;
    logic stall_done = 1'b0;
    int   stall_cnt = 0;
    int   n_alloc = 0, n_free = 0;

    ara_in_if  in_ch();
    ara_out_if out_ch();
    ara_cfg_if cfg_ch();

    aligned_range_allocator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch.sink), .o_out(out_ch.source), .i_cfg(cfg_ch.sink)
    );

    ara_result_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .mon_in(in_ch.sink), .mon_out(out_ch.sink), .mon_cfg(cfg_ch.sink),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always #5 i_clk = ~i_clk;

    logic [47:0] live_addr [$];
    logic [47:0] live_size [$];
    logic [47:0] last_alloc_size [$];

    // receiver: own stall pattern, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (stall_go && !stall_done) begin
            out_ch.ready <= 1'b0;
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt == 399) stall_done <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(logic [ara_pkg::CFG_IDX_W-1:0] idx, logic [47:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic send_beat(logic op, logic [47:0] sz, logic [5:0] lg, logic [47:0] fa);
        in_ch.opcode       <= op;
        in_ch.req_size     <= sz;
        in_ch.align_log2   <= lg;
        in_ch.free_address <= fa;
        in_ch.valid        <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == ara_pkg::OP_ALLOC) n_alloc++; else n_free++;
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic set_pool(logic [47:0] lo, logic [47:0] hi);
        drain_and_idle();
        write_reg(ara_pkg::CFG_POOL_BASE, lo);
        write_reg(ara_pkg::CFG_POOL_LIMIT, hi);
        cfg_ch.valid <= 1'b0;
        live_addr.delete();
        live_size.delete();
    endtask

    // random traffic: mostly allocs and frees of live ranges, some noise
    task automatic random_phase(int n_items, logic [47:0] lo, logic [47:0] span);
        int burst, k, i;
        logic [47:0] sz, fa;
        logic [5:0] lg;
        i = 0;
        while (i < n_items) begin
            burst = int'($urandom_range(1, 12));
            for (k = 0; k < burst && i < n_items; k++, i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        sz = 48'($urandom_range(1, 64)) << $urandom_range(0, 6);
                        if ($urandom_range(0, 15) == 0) sz = 48'({$urandom, $urandom});
                        lg = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 47))
                                                         : 6'($urandom_range(0, 8));
                        send_beat(ara_pkg::OP_ALLOC, sz, lg, 48'({$urandom, $urandom}));
                    end
                    4, 5, 6, 7: begin
                        if (live_addr.size() > 0) begin
                            int j = int'($urandom_range(0, live_addr.size() - 1));
                            fa = live_addr[j];
                            sz = live_size[j];
                            // sometimes free only a part of a range
                            if ($urandom_range(0, 3) == 0 && sz > 1) sz = sz / 2;
                            else begin
                                live_addr.delete(j);
                                live_size.delete(j);
                            end
                            send_beat(ara_pkg::OP_FREE, sz, 6'($urandom), fa);
                        end else begin
                            send_beat(ara_pkg::OP_FREE, 48'($urandom_range(1, 256)),
                                      6'($urandom), lo + 48'($urandom_range(0, 4096)));
                        end
                    end
                    8: send_beat(ara_pkg::OP_FREE, 48'($urandom_range(0, 512)), 6'($urandom),
                                 lo + 48'({$urandom, $urandom} % (64'(span) + 64'd1)));
                    default: send_beat(1'($urandom_range(0, 1)), 48'({$urandom, $urandom}),
                                       6'($urandom), 48'({$urandom, $urandom}));
                endcase
            end
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40)));
        end
    endtask

    // track granted ranges so frees hit real allocations
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready && out_ch.status == ara_pkg::ST_OK
            && out_ch.alloc_address != 0) begin
            live_addr.push_back(out_ch.alloc_address);
            live_size.push_back(last_alloc_size.size() ? last_alloc_size[0] : 48'd1);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready && last_alloc_size.size())
            void'(last_alloc_size.pop_front());
        if (i_rst_n && in_ch.valid && in_ch.ready)
            last_alloc_size.push_back(in_ch.opcode == ara_pkg::OP_ALLOC ? in_ch.req_size
                                                                         : 48'd0);
    end

    initial begin
        in_ch.valid = 0;
        in_ch.opcode = ara_pkg::OP_ALLOC;
        in_ch.req_size = 0;
        in_ch.align_log2 = 0;
        in_ch.free_address = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = ara_pkg::CFG_POOL_BASE;
        cfg_ch.data = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pool after reset
        send_beat(ara_pkg::OP_ALLOC, 48'd16, 6'd0, 48'd0);
        send_beat(ara_pkg::OP_FREE, 48'd16, 6'd0, 48'h100);
        set_pool(48'h1000, 48'h1000);
        set_pool(48'h2000, 48'h1000);
        send_beat(ara_pkg::OP_ALLOC, 48'd1, 6'd0, 48'd0);

        // full address space, field extremes
        set_pool(48'd0, 48'hFFFF_FFFF_FFFF);
        send_beat(ara_pkg::OP_ALLOC, 48'd0, 6'd0, 48'd0);
        send_beat(ara_pkg::OP_ALLOC, 48'd1, 6'd47, 48'd0);
        send_beat(ara_pkg::OP_ALLOC, 48'h10, 6'd63, 48'd0);
        send_beat(ara_pkg::OP_ALLOC, 48'hFFFF_FFFF_FFFF, 6'd0, 48'd0);
        send_beat(ara_pkg::OP_FREE, 48'd0, 6'h3F, 48'hFFFF_FFFF_FFFF);
        send_beat(ara_pkg::OP_FREE, 48'd2, 6'd0, 48'hFFFF_FFFF_FFFF);
        send_beat(ara_pkg::OP_FREE, 48'd1, 6'd0, 48'hFFFF_FFFF_FFFF);
        send_beat(ara_pkg::OP_FREE, 48'd1, 6'd0, 48'h0);
        send_beat(ara_pkg::OP_FREE, 48'h8000_0000_0000, 6'd0, 48'h8000_0000_0000);

        // small pool: split, coalesce, double free, outside-pool free
        set_pool(48'h1003, 48'h1100);
        send_beat(ara_pkg::OP_ALLOC, 48'h10, 6'd4, 48'd0);
        send_beat(ara_pkg::OP_ALLOC, 48'h10, 6'd0, 48'd0);
        send_beat(ara_pkg::OP_FREE, 48'h10, 6'd0, 48'h1010);
        send_beat(ara_pkg::OP_FREE, 48'h10, 6'd0, 48'h1010);
        send_beat(ara_pkg::OP_FREE, 48'h10, 6'd0, 48'h1020);
        send_beat(ara_pkg::OP_FREE, 48'h40, 6'd0, 48'h5000);
        send_beat(ara_pkg::OP_ALLOC, 48'h200, 6'd0, 48'd0);

        // fill the table to the limit with tiny aligned carves
        set_pool(48'h0, 48'h4000);
        for (int i = 0; i < ara_tb_pkg::TB_GAPS + 6; i++)
            send_beat(ara_pkg::OP_ALLOC, 48'd1, 6'd6, 48'd0);
        for (int i = 0; i < 40; i++)
            send_beat(ara_pkg::OP_FREE, 48'd1, 6'd0, 48'h8000 + 48'(i) * 48'd4);

        // long receiver stall while the sender keeps offering
        set_pool(48'h10000, 48'h90000);
        stall_go = 1'b1;
        random_phase(60, 48'h10000, 48'h80000);

        set_pool(48'h10000, 48'h90000);
        random_phase(700, 48'h10000, 48'h80000);
        set_pool(48'h0, 48'h800);
        random_phase(400, 48'h0, 48'h800);
        set_pool(48'hFFFF_FFF0_0000, 48'hFFFF_FFFF_FFFF);
        random_phase(400, 48'hFFFF_FFF0_0000, 48'hF_FFFF);

        drain_and_idle();
        $display("covered %0d allocate and %0d free beats, %0d results checked",
                 n_alloc, n_free, results);
        $display("pools: empty, inverted, full space, tiny, table-full, top of space");
        if (errors == 0)
            $display("tb_aligned_range_allocator_core OK");
        else
            $display("tb_aligned_range_allocator_core NOT OK");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_aligned_range_allocator_core NOT OK");
        $finish;
    end
endmodule
